/* src/dtq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtq_pkg: shared types and constants of the deadline timer queue
// Request and response payloads, slot layout, result and register codes, and
// the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package dtq_pkg;

   localparam int TIME_W   = 63;
   localparam int PERIOD_W = 40;
   localparam int HANDLE_W = 8;
   localparam int MINARM_W = 20;
   localparam int CSR_DW   = 32;
   localparam int CSR_AW   = 3;

   // Largest representable time, the saturation point of a re-insert
   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
   localparam logic [MINARM_W-1:0] MIN_ARM_RESET = 20'd100;

   // Request kinds
   localparam logic KIND_ADD  = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // Response kinds
   localparam logic [1:0] RES_ACK     = 2'd0;
   localparam logic [1:0] RES_EXPIRED = 2'd1;
   localparam logic [1:0] RES_SUMMARY = 2'd2;

   // Register index (byte address / 4)
   localparam logic [CSR_AW-3:0] CSR_MIN_ARM_DELAY = 1'b0;

   typedef struct packed {
      logic                kind;
      logic [TIME_W-1:0]   now_time;
      logic [TIME_W-1:0]   deadline;
      logic [PERIOD_W-1:0] period;
      logic [HANDLE_W-1:0] handle;
   } req_type;

   typedef struct packed {
      logic [1:0]          result_kind;
      logic [HANDLE_W-1:0] expired_handle;
      logic                earliest_changed;
      logic                table_full;
      logic                next_valid;
      logic [TIME_W-1:0]   next_deadline;
      logic [TIME_W-1:0]   arm_delay;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic [TIME_W-1:0]   deadline;
      logic [PERIOD_W-1:0] period;
      logic [HANDLE_W-1:0] handle;
   } slot_type;

   typedef struct packed {
      logic load;          // capture the request
      logic scan_start;    // begin a pass over all slots
      logic mark_mode;     // this pass marks expired slots
      logic add_commit;    // store the added timer, send the acknowledgment
      logic pick_commit;   // retire or re-insert the selected timer, send its handle
      logic sub_load;      // form next deadline minus now
      logic emit_summary;  // send the tick summary
   } cmd_type;

   typedef struct packed {
      logic scan_busy;
      logic found;
   } sts_type;

endpackage

`default_nettype wire

/* src/deadline_timer_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deadline_timer_queue: table of pending timers ordered by deadline
// Adds timers, expires them on ticks in deadline/handle order, re-inserts
// repeating timers and reports the next deadline with a clamped arm delay.
// ----------------------------------------------------------------------------
//
//   channel   ports                    handshake
//   -------   ----------------------   ------------------------------------
//   request   start, busy, req_data    taken when start is high, busy low
//   response  rsp_valid, rsp_data      one-cycle strobe, no back-pressure
//   config    csr_* (APB style)        written on psel & penable & pwrite
//
// Passes: every request walks the slot memory once per pass, one slot per
// cycle through its single read port. An add runs one pass, then commits,
// and its acknowledgment is registered. A tick that expires k timers runs
// k+1 passes, then a subtract state and a summary state. Reset clears the
// valid bits and the sequencer and sets the minimum arm delay register to
// its default; the slot memory itself is not cleared. The response side
// cannot stall: each result is presented for one cycle only.
// ----------------------------------------------------------------------------
module deadline_timer_queue #(
   parameter int DEPTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          start,
   output logic                               busy,
   input  wire dtq_pkg::req_type              req_data,
   // response channel
   output logic                               rsp_valid,
   output dtq_pkg::rsp_type                   rsp_data,
   // configuration port
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [dtq_pkg::CSR_AW-1:0]    csr_paddr,
   input  wire logic [dtq_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [dtq_pkg::CSR_DW-1:0]         csr_prdata,
   output logic                               csr_pready
);
   import dtq_pkg::*;

   cmd_type                 cmd;
   sts_type                 sts;
   logic [MINARM_W-1:0]     min_arm_ff;
   logic [CSR_AW-3:0]       csr_idx;
   logic                    csr_wr;

   // Register file: one register, word addressed
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_AW-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      unique case (csr_idx)
         CSR_MIN_ARM_DELAY: csr_prdata = CSR_DW'(min_arm_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // Hold the minimum arm delay; drop writes to unknown addresses
   always_ff @(posedge clock) begin
      if (reset) begin
         min_arm_ff <= MIN_ARM_RESET;
      end else if (csr_wr && (csr_idx == CSR_MIN_ARM_DELAY)) begin
         min_arm_ff <= csr_pwdata[MINARM_W-1:0];
      end
   end

   // Sequencer: decides which pass runs and when a response goes out
   dtq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_data.kind),
      .sts      (sts),
      .cmd      (cmd),
      .busy     (busy)
   );

   // Slot memory, scan comparators and response register
   dtq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_data      (req_data),
      .min_arm_delay (min_arm_ff),
      .sts           (sts),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data)
   );

   // A request accepted always makes the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   // The final response of a request is never followed at once by another
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last) |=> !rsp_valid)
      else $error("response directly after a final response");

   // An add commit yields exactly one final acknowledgment
   a_add_ack: assert property (@(posedge clock) disable iff (reset)
      cmd.add_commit |=> (rsp_valid && (rsp_data.result_kind == RES_ACK) && rsp_data.last))
      else $error("add commit without final acknowledgment");

   // Expired handles never close a tick; only the summary does
   a_expired_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.result_kind == RES_EXPIRED)) |-> !rsp_data.last)
      else $error("expired handle marked as final response");

endmodule

`default_nettype wire

/* src/dtq_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtq_ctrl: sequencer of the deadline timer queue
// Steps an add through one slot pass and a tick through repeated selection
// passes followed by the summary.
// ----------------------------------------------------------------------------
module dtq_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic            req_kind,
   input  wire dtq_pkg::sts_type sts,
   output dtq_pkg::cmd_type     cmd,
   output logic                 busy
);
   import dtq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD_SCAN,
      S_ADD_DONE,
      S_TICK_SCAN,
      S_TICK_PICK,
      S_TICK_SUB,
      S_TICK_SUM
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load       = 1'b1;
               cmd.scan_start = 1'b1;
               cmd.mark_mode  = (req_kind == KIND_TICK);
               state_in       = (req_kind == KIND_TICK) ? S_TICK_SCAN : S_ADD_SCAN;
            end
         end
         S_ADD_SCAN: begin
            if (!sts.scan_busy) state_in = S_ADD_DONE;
         end
         S_ADD_DONE: begin
            cmd.add_commit = 1'b1;
            state_in       = S_IDLE;
         end
         S_TICK_SCAN: begin
            if (!sts.scan_busy) state_in = S_TICK_PICK;
         end
         S_TICK_PICK: begin
            if (sts.found) begin
               cmd.pick_commit = 1'b1;
               cmd.scan_start  = 1'b1;
               state_in        = S_TICK_SCAN;
            end else begin
               state_in = S_TICK_SUB;
            end
         end
         S_TICK_SUB: begin
            cmd.sub_load = 1'b1;
            state_in     = S_TICK_SUM;
         end
         S_TICK_SUM: begin
            cmd.emit_summary = 1'b1;
            state_in         = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

`default_nettype wire

/* src/dtq_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtq_datapath: slot memory and scan unit of the deadline timer queue
// Reads one slot per cycle, tracks the earliest valid deadline and the first
// marked timer in deadline/handle/index order, and forms the responses.
// ----------------------------------------------------------------------------
module dtq_datapath #(
   parameter int DEPTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire dtq_pkg::cmd_type                 cmd,
   input  wire dtq_pkg::req_type                 req_data,
   input  wire logic [dtq_pkg::MINARM_W-1:0]     min_arm_delay,
   output dtq_pkg::sts_type                      sts,
   output logic                                  rsp_valid,
   output dtq_pkg::rsp_type                      rsp_data
);
   import dtq_pkg::*;

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

   slot_type mem [DEPTH];

   req_type             item_ff;
   logic                issue_ff, ev_ff, mark_mode_ff;
   logic [IW-1:0]       cnt_ff, ev_idx_ff;
   slot_type            rd_ff;
   logic [DEPTH-1:0]    valid_ff, valid_in;
   logic [DEPTH-1:0]    mark_ff, mark_in;
   logic                any_ff, found_ff;
   logic [TIME_W-1:0]   min_ff, best_dl_ff, diff_ff, diff_in;
   logic [HANDLE_W-1:0] best_h_ff;
   logic [PERIOD_W-1:0] best_per_ff;
   logic [IW-1:0]       best_idx_ff, free_idx;
   logic                free_any;
   logic                ev_valid, ev_mark, take_min, take_best;
   logic [TIME_W:0]     reins_sum;
   logic [TIME_W-1:0]   reins_dl, clamp_dl, min_ext;
   logic                mem_we;
   logic [IW-1:0]       mem_waddr;
   slot_type            mem_wdata;
   logic                rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   // Slot under evaluation
   always_comb begin
      ev_valid  = valid_ff[ev_idx_ff];
      ev_mark   = mark_mode_ff ? (ev_valid && (rd_ff.deadline <= item_ff.now_time))
                               : mark_ff[ev_idx_ff];
      take_min  = ev_ff && ev_valid && (!any_ff || (rd_ff.deadline < min_ff));
      take_best = ev_ff && ev_mark &&
                  (!found_ff || (rd_ff.deadline < best_dl_ff) ||
                   ((rd_ff.deadline == best_dl_ff) && (rd_ff.handle < best_h_ff)));
   end

   // Lowest free slot
   always_comb begin
      free_idx = '0;
      free_any = 1'b0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IW'(i);
            free_any = 1'b1;
         end
      end
   end

   // Repeat re-insert at now plus period, saturating
   always_comb begin
      reins_sum = {1'b0, item_ff.now_time} + (TIME_W + 1)'(best_per_ff);
      reins_dl  = reins_sum[TIME_W] ? TIME_MAX : reins_sum[TIME_W-1:0];
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = best_idx_ff;
      mem_wdata = '{deadline: reins_dl, period: best_per_ff, handle: best_h_ff};
      valid_in  = valid_ff;
      mark_in   = mark_ff;
      if (cmd.add_commit && free_any) begin
         mem_we              = 1'b1;
         mem_waddr           = free_idx;
         mem_wdata           = '{deadline: item_ff.deadline, period: item_ff.period,
                                 handle: item_ff.handle};
         valid_in[free_idx]  = 1'b1;
      end
      if (cmd.pick_commit) begin
         mark_in[best_idx_ff] = 1'b0;
         if (best_per_ff != '0) mem_we = 1'b1;
         else valid_in[best_idx_ff] = 1'b0;
      end
      if (ev_ff && mark_mode_ff) mark_in[ev_idx_ff] = ev_mark;
   end

   // Arm delay: the difference is registered, the clamp follows
   always_comb begin
      diff_in  = (min_ff > item_ff.now_time) ? (min_ff - item_ff.now_time) : '0;
      min_ext  = TIME_W'(min_arm_delay);
      clamp_dl = (diff_ff < min_ext) ? min_ext : diff_ff;
   end

   always_comb begin
      rsp_in       = '0;
      rsp_valid_in = 1'b0;
      if (cmd.add_commit) begin
         rsp_valid_in            = 1'b1;
         rsp_in.result_kind      = RES_ACK;
         rsp_in.earliest_changed = free_any && (!any_ff || (item_ff.deadline < min_ff));
         rsp_in.table_full       = !free_any;
         rsp_in.last             = 1'b1;
      end else if (cmd.pick_commit) begin
         rsp_valid_in          = 1'b1;
         rsp_in.result_kind    = RES_EXPIRED;
         rsp_in.expired_handle = best_h_ff;
      end else if (cmd.emit_summary) begin
         rsp_valid_in         = 1'b1;
         rsp_in.result_kind   = RES_SUMMARY;
         rsp_in.next_valid    = any_ff;
         rsp_in.next_deadline = any_ff ? min_ff : '0;
         rsp_in.arm_delay     = any_ff ? clamp_dl : '0;
         rsp_in.last          = 1'b1;
      end
   end

   // Slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rd_ff <= mem[cnt_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff     <= 1'b0;
         ev_ff        <= 1'b0;
         cnt_ff       <= '0;
         mark_mode_ff <= 1'b0;
         valid_ff     <= '0;
         mark_ff      <= '0;
         any_ff       <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid    <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         mark_ff   <= mark_in;
         rsp_valid <= rsp_valid_in;
         ev_ff     <= issue_ff;
         if (cmd.scan_start) begin
            issue_ff     <= 1'b1;
            cnt_ff       <= '0;
            mark_mode_ff <= cmd.mark_mode;
            any_ff       <= 1'b0;
            found_ff     <= 1'b0;
         end else begin
            if (issue_ff) begin
               if (cnt_ff == LAST_IDX) issue_ff <= 1'b0;
               else cnt_ff <= cnt_ff + 1'b1;
            end
            if (take_min) any_ff <= 1'b1;
            if (take_best) found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      ev_idx_ff <= cnt_ff;
      if (cmd.load) item_ff <= req_data;
      if (take_min) min_ff <= rd_ff.deadline;
      if (take_best) begin
         best_dl_ff  <= rd_ff.deadline;
         best_h_ff   <= rd_ff.handle;
         best_per_ff <= rd_ff.period;
         best_idx_ff <= ev_idx_ff;
      end
      if (cmd.sub_load) diff_ff <= diff_in;
      if (rsp_valid_in) rsp_ff <= rsp_in;
   end

   assign sts.scan_busy = issue_ff | ev_ff;
   assign sts.found     = found_ff;
   assign rsp_data      = rsp_ff;

endmodule

`default_nettype wire
